// File: design/stx_etx_lrc_frame_classifier_core_macros.svh
// Assertion macros used by the checker file.
`ifndef STX_ETX_LRC_FRAME_CLASSIFIER_CORE_MACROS_SVH
`define STX_ETX_LRC_FRAME_CLASSIFIER_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is active.
`define SEL_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is active.
`define SEL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/selc_pkg.sv
package selc_pkg;

    localparam int POS_W           = 12;
    localparam int N_W             = POS_W + 1;
    localparam int HEAD_LEN        = 13;
    localparam int HEAD_BASE       = 11;
    localparam int MIN_FRAME_BYTES = 13;
    localparam int MAX_FRAME_DEF   = 2048;

    localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};

    localparam logic [7:0] STX_BYTE  = 8'h02;
    localparam logic [7:0] ETX_BYTE  = 8'h03;
    localparam logic [7:0] ACK_BYTE  = 8'h06;
    localparam logic [7:0] NAK_BYTE  = 8'h15;
    localparam logic [7:0] CONS_ERR_BYTE = 8'h58;

    localparam logic [7:0] PATH_REPLY = 8'h04;
    localparam logic [7:0] PATH_DATA  = 8'h05;
    localparam logic [7:0] PATH_TIP   = 8'h07;

    localparam logic [1:0] WF_OTHER     = 2'd0;
    localparam logic [1:0] WF_SIGN_IN   = 2'd1;
    localparam logic [1:0] WF_LINK_TEST = 2'd2;

    typedef enum logic [2:0] {
        ERR_NONE      = 3'd0,
        ERR_TOO_LONG  = 3'd1,
        ERR_TOO_SHORT = 3'd2,
        ERR_BAD_START = 3'd3,
        ERR_BAD_END   = 3'd4,
        ERR_LENGTH    = 3'd5,
        ERR_CHECK     = 3'd6
    } frame_err_t;

    typedef enum logic [3:0] {
        FT_UNKNOWN       = 4'd0,
        FT_CARD_CONSUME  = 4'd1,
        FT_POS_CONSUME   = 4'd2,
        FT_SIGN_CONFIRM  = 4'd3,
        FT_LINK_OK       = 4'd4,
        FT_SIGN_VERIFY   = 4'd5,
        FT_LINK_ERROR    = 4'd6,
        FT_CONSUME_ERROR = 4'd7,
        FT_NOT_SIGNED    = 4'd8,
        FT_CONSUME_DATA  = 4'd9,
        FT_CORRECTION    = 4'd10,
        FT_SIGN_IN_DATA  = 4'd11,
        FT_CONSUME_TIP   = 4'd12
    } frame_type_t;

    typedef logic [HEAD_LEN-1:0][7:0] head_bytes_t;

    typedef struct packed {
        frame_type_t frame_type;
        frame_err_t  frame_error;
        logic [7:0]  route_byte;
        logic [7:0]  consume_error_code;
        logic        ever_recognized;
    } frame_result_t;

endpackage

// File: design/stx_etx_lrc_frame_classifier_core.sv
// Channel | Ports                                  | Transfer
// input   | s_valid s_ready s_data_byte s_last_byte | one frame byte per transaction
// result  | m_valid m_ready m_frame_type ...        | one transaction per frame end
// config  | cfg_wr_en cfg_wr_data                   | write on enable, no wait
// One byte is accepted per cycle while s_ready is high. Each byte waits in an input
// register and the tracker processes it as it leaves, so a frame's result and m_valid
// are loaded into the output registers together as its last byte leaves that register.
// A stalled result holds the tracker stage; s_ready falls only when the input
// register is full and the output register is held.
// Reset (aresetn low, synchronous) clears frame state, the stored error byte,
// the sticky flag and the workflow register.
module stx_etx_lrc_frame_classifier_core #(
    parameter int MAX_FRAME_BYTES = selc_pkg::MAX_FRAME_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_wr_en,
    input  logic [1:0] cfg_wr_data,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_data_byte,
    input  logic       s_last_byte,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [3:0] m_frame_type,
    output logic [2:0] m_frame_error,
    output logic [7:0] m_route_byte,
    output logic [7:0] m_consume_error_code,
    output logic       m_ever_recognized
);
    import selc_pkg::*;

    logic          in_valid_reg, in_valid_next;
    logic [7:0]    in_data_reg;
    logic          in_last_reg;
    logic          out_valid_reg, out_valid_next;
    frame_result_t out_res_reg;
    logic [1:0]    workflow_reg;
    logic          stall;
    logic          step_en;
    frame_result_t tracker_res;

    assign stall   = out_valid_reg && !m_ready;
    assign step_en = in_valid_reg && !stall;
    assign s_ready = !in_valid_reg || !stall;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end else if (step_en) begin
            in_valid_next = 1'b0;
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (!stall) out_valid_next = step_en && in_last_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            workflow_reg  <= WF_OTHER;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en) workflow_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data_byte;
            in_last_reg <= s_last_byte;
        end
        if (step_en && in_last_reg) out_res_reg <= tracker_res;
    end

    selc_frame_tracker #(
        .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
    ) u_tracker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .step_en        (step_en),
        .data_byte      (in_data_reg),
        .last_byte      (in_last_reg),
        .workflow_state (workflow_reg),
        .result         (tracker_res)
    );

    assign m_valid              = out_valid_reg;
    assign m_frame_type         = out_res_reg.frame_type;
    assign m_frame_error        = out_res_reg.frame_error;
    assign m_route_byte         = out_res_reg.route_byte;
    assign m_consume_error_code = out_res_reg.consume_error_code;
    assign m_ever_recognized    = out_res_reg.ever_recognized;

endmodule

// File: design/selc_classifier.sv
module selc_classifier (
    input  logic [7:0]           path_byte,
    input  selc_pkg::head_bytes_t payload,
    input  logic [1:0]           workflow_state,
    output selc_pkg::frame_type_t frame_type
);
    import selc_pkg::*;

    always_comb begin
        frame_type = FT_UNKNOWN;
        unique case (path_byte)
            PATH_REPLY: begin
                if (payload[0] == 8'h57 && payload[1] == 8'h31) begin
                    if (payload[3] == 8'h30 && payload[4] == 8'h31) begin
                        frame_type = FT_CARD_CONSUME;
                    end else if (payload[3] == 8'h30 && payload[4] == 8'h32) begin
                        frame_type = FT_POS_CONSUME;
                    end
                end else if (payload[0] == ACK_BYTE && payload[2] == 8'h30 &&
                             payload[3] == 8'h30) begin
                    if (workflow_state == WF_SIGN_IN) begin
                        frame_type = FT_SIGN_CONFIRM;
                    end else if (workflow_state == WF_LINK_TEST) begin
                        frame_type = FT_LINK_OK;
                    end
                end else if (payload[0] == NAK_BYTE) begin
                    if (workflow_state == WF_SIGN_IN) begin
                        frame_type = FT_SIGN_VERIFY;
                    end else if (workflow_state == WF_LINK_TEST) begin
                        frame_type = FT_LINK_ERROR;
                    end
                end
            end
            PATH_DATA: begin
                if (payload[0] == NAK_BYTE) begin
                    if (payload[2] == CONS_ERR_BYTE && payload[3] == CONS_ERR_BYTE) begin
                        frame_type = FT_CONSUME_ERROR;
                    end else if (payload[2] == 8'h41 && payload[3] == 8'h34) begin
                        frame_type = FT_NOT_SIGNED;
                    end else if (payload[2] == CONS_ERR_BYTE && payload[3] == 8'h35) begin
                        frame_type = FT_SIGN_VERIFY;
                    end
                end else if (payload[0] == 8'h60 && payload[12] == 8'h00) begin
                    case (payload[11])
                        8'h02:   frame_type = FT_CONSUME_DATA;
                        8'h04:   frame_type = FT_CORRECTION;
                        8'h08:   frame_type = FT_SIGN_IN_DATA;
                        default: frame_type = FT_UNKNOWN;
                    endcase
                end
            end
            PATH_TIP: begin
                if (payload[0] == 8'h39 && payload[1] == 8'h37) begin
                    frame_type = FT_CONSUME_TIP;
                end
            end
            default: frame_type = FT_UNKNOWN;
        endcase
    end

endmodule

// File: design/selc_frame_tracker.sv
module selc_frame_tracker #(
    parameter int MAX_FRAME_BYTES = selc_pkg::MAX_FRAME_DEF
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    step_en,
    input  logic [7:0]              data_byte,
    input  logic                    last_byte,
    input  logic [1:0]              workflow_state,
    output selc_pkg::frame_result_t result
);
    import selc_pkg::*;

    logic [POS_W-1:0] pos_reg;
    logic [7:0]       xor_reg;
    logic [7:0]       start_reg;
    logic [15:0]      len_reg;
    logic [7:0]       path_reg;
    logic [7:0]       prev_reg;
    head_bytes_t      head_reg;
    logic [7:0]       err_byte_reg;
    logic             recog_reg;

    logic [N_W-1:0]   frame_len;
    logic [15:0]      len_expect;
    head_bytes_t      payload;
    frame_err_t       err;
    frame_type_t      cls_type;
    frame_type_t      final_type;

    // Frame length counts the byte now in hand.
    assign frame_len  = {1'b0, pos_reg} + N_W'(1);
    assign len_expect = 16'(frame_len) - 16'd5;

    // Payload bytes not covered by this frame read as zero.
    always_comb begin
        for (int k = 0; k < HEAD_LEN; k++) begin
            payload[k] = (pos_reg >= POS_W'(MIN_FRAME_BYTES + k)) ? head_reg[k] : 8'h00;
        end
    end

    always_comb begin
        if (frame_len > N_W'(MAX_FRAME_BYTES)) begin
            err = ERR_TOO_LONG;
        end else if (frame_len < N_W'(MIN_FRAME_BYTES)) begin
            err = ERR_TOO_SHORT;
        end else if (start_reg != STX_BYTE) begin
            err = ERR_BAD_START;
        end else if (prev_reg != ETX_BYTE) begin
            err = ERR_BAD_END;
        end else if (len_reg != len_expect) begin
            err = ERR_LENGTH;
        end else if (xor_reg != data_byte) begin
            err = ERR_CHECK;
        end else begin
            err = ERR_NONE;
        end
    end

    selc_classifier u_classifier (
        .path_byte      (path_reg),
        .payload        (payload),
        .workflow_state (workflow_state),
        .frame_type     (cls_type)
    );

    assign final_type = (err == ERR_NONE) ? cls_type : FT_UNKNOWN;

    always_comb begin
        result.frame_type  = final_type;
        result.frame_error = err;
        // A last byte at offset 3 is itself the path byte.
        result.route_byte  = (pos_reg == POS_W'(3)) ? data_byte : path_reg;
        result.consume_error_code =
            (final_type == FT_CONSUME_ERROR) ? CONS_ERR_BYTE : err_byte_reg;
        result.ever_recognized = recog_reg | (final_type != FT_UNKNOWN);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg      <= '0;
            xor_reg      <= '0;
            start_reg    <= '0;
            len_reg      <= '0;
            path_reg     <= '0;
            prev_reg     <= '0;
            err_byte_reg <= '0;
            recog_reg    <= 1'b0;
        end else if (step_en) begin
            if (last_byte) begin
                pos_reg   <= '0;
                xor_reg   <= '0;
                start_reg <= '0;
                len_reg   <= '0;
                path_reg  <= '0;
                prev_reg  <= '0;
                err_byte_reg <= result.consume_error_code;
                recog_reg    <= result.ever_recognized;
            end else begin
                if (pos_reg == POS_W'(0)) start_reg <= data_byte;
                if (pos_reg == POS_W'(1)) len_reg[15:8] <= data_byte;
                if (pos_reg == POS_W'(2)) len_reg[7:0] <= data_byte;
                if (pos_reg == POS_W'(3)) path_reg <= data_byte;
                if (pos_reg != '0) xor_reg <= xor_reg ^ data_byte;
                prev_reg <= data_byte;
                if (pos_reg != POS_MAX) pos_reg <= pos_reg + POS_W'(1);
            end
        end
    end

    // Capture the payload head; stale entries are masked by length.
    always_ff @(posedge aclk) begin
        if (step_en) begin
            for (int k = 0; k < HEAD_LEN; k++) begin
                if (pos_reg == POS_W'(HEAD_BASE + k)) head_reg[k] <= data_byte;
            end
        end
    end

endmodule

// File: design/selc_checker.sv
`include "stx_etx_lrc_frame_classifier_core_macros.svh"

module selc_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       m_valid,
    input logic       m_ready,
    input logic [3:0] m_frame_type,
    input logic [2:0] m_frame_error,
    input logic [7:0] m_consume_error_code,
    input logic       m_ever_recognized
);
    import selc_pkg::*;

    `SEL_ASSERT_NEXT(a_result_held, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_frame_type) && $stable(m_frame_error), "result changed while stalled")

    `SEL_ASSERT_NOW(a_error_no_type, aclk, aresetn, m_valid && m_frame_error != ERR_NONE, m_frame_type == FT_UNKNOWN, "typed frame carries an error")

    `SEL_ASSERT_NOW(a_type_sets_flag, aclk, aresetn, m_valid && m_frame_type != FT_UNKNOWN, m_ever_recognized, "recognized frame without sticky flag")

    `SEL_ASSERT_NOW(a_consume_err_code, aclk, aresetn, m_valid && m_frame_type == FT_CONSUME_ERROR, m_consume_error_code == CONS_ERR_BYTE, "consume error byte not stored")

endmodule

bind stx_etx_lrc_frame_classifier_core selc_checker u_selc_checker (
    .aclk                 (aclk),
    .aresetn              (aresetn),
    .m_valid              (m_valid),
    .m_ready              (m_ready),
    .m_frame_type         (m_frame_type),
    .m_frame_error        (m_frame_error),
    .m_consume_error_code (m_consume_error_code),
    .m_ever_recognized    (m_ever_recognized)
);
